@@ rtl/tga_truecolor_rle_decoder_macros.svh @@
`ifndef TGA_TRUECOLOR_RLE_DECODER_MACROS_SVH
`define TGA_TRUECOLOR_RLE_DECODER_MACROS_SVH

// Both checks sample on clk and are off while arst_n is low; the module
// that uses them must have ports of those names.

// Same-cycle implication.
`define TGA_RLE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga_rle: same-cycle check failed");

// Next-cycle implication.
`define TGA_RLE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga_rle: next-cycle check failed");

`endif

@@ rtl/tga_rle_pkg.sv @@
package tga_rle_pkg;

	// decode phases
	localparam logic [2:0] PH_HEAD   = 3'd0;
	localparam logic [2:0] PH_REPEAT = 3'd1;
	localparam logic [2:0] PH_RAW    = 3'd2;
	localparam logic [2:0] PH_PLAIN  = 3'd3;
	localparam logic [2:0] PH_DRAIN  = 3'd4;

	// result status codes
	localparam logic [2:0] ST_PIXEL       = 3'd0;
	localparam logic [2:0] ST_NO_HEADER   = 3'd1;
	localparam logic [2:0] ST_SHORT_REP   = 3'd2;
	localparam logic [2:0] ST_SHORT_RAW   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW    = 3'd4;
	localparam logic [2:0] ST_SHORT_PLAIN = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_RUN_LENGTH_MODE = 2'd0;
	localparam logic [1:0] REG_PIXEL_HAS_ALPHA = 2'd1;
	localparam logic [1:0] REG_PIXEL_TOTAL     = 2'd2;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_rgba;
		logic [7:0]  copies;
		logic [2:0]  status;
		logic        image_done;
	} out_item_t;

	typedef struct packed {
		logic        run_length_mode;
		logic        pixel_has_alpha;
		logic [31:0] pixel_total;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] pixels_left;
		logic [7:0]  packet_left;
		logic        overflow_pending;
		logic [1:0]  byte_in_pixel;
		logic [23:0] pixel_bytes;
	} state_t;

endpackage

@@ rtl/tga_rle_step.sv @@
module tga_rle_step (
	input  tga_rle_pkg::cfg_t      cfg,
	input  tga_rle_pkg::state_t    cur,
	input  tga_rle_pkg::in_item_t  item,
	output tga_rle_pkg::state_t    nxt,
	output logic                   res_valid,
	output tga_rle_pkg::out_item_t res
);

	tga_rle_pkg::state_t eff;
	logic [7:0]  b;
	logic        last;
	logic [7:0]  count;
	logic        complete;
	logic [7:0]  dec_amt;
	logic [31:0] pl_dec;
	logic [7:0]  pk_dec;
	logic [7:0]  red;
	logic [7:0]  alpha;
	logic [31:0] rgba;
	logic        do_fail;
	logic        do_put;
	logic        put_done;
	logic        ends;
	logic [2:0]  code;
	logic [7:0]  put_copies;

	assign b = item.data_byte;
	assign last = item.end_of_data;

	always_comb begin
		// working state after the image-start check
		eff = cur;
		if (cur.phase > tga_rle_pkg::PH_DRAIN) begin
			eff.phase = tga_rle_pkg::PH_HEAD;
		end
		if (cur.phase != tga_rle_pkg::PH_DRAIN && cur.pixels_left == 32'd0) begin
			eff.pixels_left = (cfg.pixel_total != 32'd0) ? cfg.pixel_total : 32'd1;
			eff.phase = cfg.run_length_mode ? tga_rle_pkg::PH_HEAD : tga_rle_pkg::PH_PLAIN;
			eff.packet_left = 8'd0;
			eff.overflow_pending = 1'b0;
			eff.byte_in_pixel = 2'd0;
		end
	end

	assign count = {1'b0, b[6:0]} + 8'd1;
	assign complete = (eff.byte_in_pixel == 2'd3) ||
		(eff.byte_in_pixel == 2'd2 && !cfg.pixel_has_alpha);
	assign dec_amt = (eff.phase == tga_rle_pkg::PH_REPEAT) ? eff.packet_left : 8'd1;
	assign pl_dec = eff.pixels_left - {24'd0, dec_amt};
	assign pk_dec = eff.packet_left - 8'd1;
	assign red = (eff.byte_in_pixel == 2'd3) ? eff.pixel_bytes[23:16] : b;
	assign alpha = (eff.byte_in_pixel == 2'd3 && cfg.pixel_has_alpha) ? b : 8'hFF;
	assign rgba = {alpha, eff.pixel_bytes[7:0], eff.pixel_bytes[15:8], red};

	always_comb begin
		nxt = eff;
		do_fail = 1'b0;
		do_put = 1'b0;
		put_done = 1'b0;
		ends = 1'b0;
		code = tga_rle_pkg::ST_PIXEL;
		put_copies = 8'd1;

		if (cur.phase == tga_rle_pkg::PH_DRAIN) begin
			nxt = cur;
			ends = last;
		end else if (eff.phase == tga_rle_pkg::PH_HEAD) begin
			nxt.packet_left = count;
			nxt.overflow_pending = {24'd0, count} > eff.pixels_left;
			nxt.byte_in_pixel = 2'd0;
			nxt.phase = b[7] ? tga_rle_pkg::PH_REPEAT : tga_rle_pkg::PH_RAW;
			if (last) begin
				do_fail = 1'b1;
				code = b[7] ? tga_rle_pkg::ST_SHORT_REP : tga_rle_pkg::ST_SHORT_RAW;
			end
		end else if (!complete) begin
			case (eff.byte_in_pixel)
				2'd0: nxt.pixel_bytes = {16'd0, b};
				2'd1: nxt.pixel_bytes = eff.pixel_bytes | {8'd0, b, 8'd0};
				2'd2: nxt.pixel_bytes = eff.pixel_bytes | {b, 16'd0};
				default: nxt.pixel_bytes = eff.pixel_bytes;
			endcase
			nxt.byte_in_pixel = eff.byte_in_pixel + 2'd1;
			if (last) begin
				do_fail = 1'b1;
				if (eff.phase == tga_rle_pkg::PH_REPEAT) begin
					code = tga_rle_pkg::ST_SHORT_REP;
				end else if (eff.phase == tga_rle_pkg::PH_RAW) begin
					code = tga_rle_pkg::ST_SHORT_RAW;
				end else begin
					code = tga_rle_pkg::ST_SHORT_PLAIN;
				end
			end
		end else begin
			nxt.byte_in_pixel = 2'd0;
			if (eff.phase == tga_rle_pkg::PH_PLAIN) begin
				nxt.pixels_left = pl_dec;
				if (pl_dec == 32'd0) begin
					ends = 1'b1;
					do_put = 1'b1;
					put_done = 1'b1;
				end else if (last) begin
					do_fail = 1'b1;
					code = tga_rle_pkg::ST_SHORT_PLAIN;
				end else begin
					do_put = 1'b1;
				end
			end else if (eff.phase == tga_rle_pkg::PH_RAW && pk_dec != 8'd0) begin
				// pixel inside a raw packet
				nxt.packet_left = pk_dec;
				if (last) begin
					do_fail = 1'b1;
					code = tga_rle_pkg::ST_SHORT_RAW;
				end else if (!eff.overflow_pending) begin
					nxt.pixels_left = pl_dec;
					do_put = 1'b1;
				end
			end else if (eff.overflow_pending) begin
				do_fail = 1'b1;
				code = tga_rle_pkg::ST_OVERFLOW;
			end else begin
				// packet ends: repeat pixel or last raw pixel
				nxt.packet_left = 8'd0;
				nxt.pixels_left = pl_dec;
				put_copies = dec_amt;
				if (pl_dec == 32'd0) begin
					ends = 1'b1;
					do_put = 1'b1;
					put_done = 1'b1;
				end else if (last) begin
					do_fail = 1'b1;
					code = tga_rle_pkg::ST_NO_HEADER;
				end else begin
					nxt.phase = tga_rle_pkg::PH_HEAD;
					do_put = 1'b1;
				end
			end
		end

		if (ends || do_fail) begin
			nxt.pixels_left = 32'd0;
			nxt.packet_left = 8'd0;
			nxt.overflow_pending = 1'b0;
			nxt.byte_in_pixel = 2'd0;
			nxt.phase = last ? tga_rle_pkg::PH_HEAD : tga_rle_pkg::PH_DRAIN;
		end

		res_valid = do_fail || do_put;
		res = '0;
		if (do_fail) begin
			res.status = code;
			res.image_done = 1'b1;
		end else if (do_put) begin
			res.pixel_rgba = rgba;
			res.copies = put_copies;
			res.status = tga_rle_pkg::ST_PIXEL;
			res.image_done = put_done;
		end
	end

endmodule

@@ rtl/tga_rle_outreg.sv @@
module tga_rle_outreg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   load_valid,
	input  tga_rle_pkg::out_item_t load_item,
	output logic                   free,
	output logic                   pix_valid,
	input  logic                   pix_ready,
	output tga_rle_pkg::out_item_t pix_item
);

	logic                   valid_q;
	tga_rle_pkg::out_item_t item_q;

	// the slot frees up in the same cycle its result is taken
	assign free = !valid_q || pix_ready;
	assign pix_valid = valid_q;
	assign pix_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (pix_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			item_q <= load_item;
		end
	end

endmodule

@@ rtl/tga_truecolor_rle_decoder.sv @@
// Truecolor TGA pixel-data decoder.
// byte channel (byte_valid/byte_ready/byte_item): one pixel-data byte per
//   transfer, with end_of_data on the last byte of the file.
// pix channel (pix_valid/pix_ready/pix_item): one RGBA pixel with a copy
//   count, or an error status, per transfer; image_done marks the end.
// cfg port: cfg_we writes cfg_wdata into register cfg_index (0 run-length
//   mode, 1 pixel has alpha, 2 pixel total); write only while idle.
// Throughput: one byte per cycle while no result waits on pix_ready, so one
//   pixel per 3 or 4 bytes, or a repeat packet per 4 or 5 bytes. Rate is set by
//   the combinational state update between the state and output registers.
// Latency: a result is on pix_item the cycle after the transfer of the byte
//   that produced it.
// Reset: registers return to run-length mode, BGRA pixels, pixel total 1,
//   and the decoder waits for the first byte of a new image.
// Stall: while a result waits on pix_ready low, byte_ready drops; once it is
//   taken, the next byte is accepted in the same cycle.
`include "tga_truecolor_rle_decoder_macros.svh"

module tga_truecolor_rle_decoder (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                      byte_valid,
	output logic                                      byte_ready,
	input  tga_rle_pkg::in_item_t                     byte_item,
	output logic                                      pix_valid,
	input  logic                                      pix_ready,
	output tga_rle_pkg::out_item_t                    pix_item
);

	tga_rle_pkg::cfg_t      cfg_q;
	tga_rle_pkg::state_t    state_q;
	tga_rle_pkg::state_t    state_nxt;
	logic                   res_valid;
	tga_rle_pkg::out_item_t res_item;
	logic                   byte_xfer;

	assign byte_xfer = byte_valid && byte_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_length_mode <= 1'b1;
			cfg_q.pixel_has_alpha <= 1'b1;
			cfg_q.pixel_total <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tga_rle_pkg::REG_RUN_LENGTH_MODE: cfg_q.run_length_mode <= cfg_wdata[0];
				tga_rle_pkg::REG_PIXEL_HAS_ALPHA: cfg_q.pixel_has_alpha <= cfg_wdata[0];
				tga_rle_pkg::REG_PIXEL_TOTAL:     cfg_q.pixel_total <= cfg_wdata;
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// decode state: advance on every byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: tga_rle_pkg::PH_HEAD, default: '0};
		end else if (byte_xfer) begin
			state_q <= state_nxt;
		end
	end

	tga_rle_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.item      (byte_item),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res_item)
	);

	// result register; it also decides when the next byte can be taken
	tga_rle_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (byte_xfer),
		.load_valid (res_valid),
		.load_item  (res_item),
		.free       (byte_ready),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_item   (pix_item)
	);

	`TGA_RLE_ASSERT_IMP(a_stall_blocks_input, pix_valid && !pix_ready, !byte_ready)
	`TGA_RLE_ASSERT_IMP(a_error_result_shape,
		pix_valid && pix_item.status != tga_rle_pkg::ST_PIXEL,
		pix_item.image_done && pix_item.pixel_rgba == 32'd0 && pix_item.copies == 8'd0)
	`TGA_RLE_ASSERT_IMP(a_drain_is_clear, state_q.phase == tga_rle_pkg::PH_DRAIN,
		state_q.pixels_left == 32'd0 && state_q.byte_in_pixel == 2'd0)
	`TGA_RLE_ASSERT_IMP(a_packet_count_in_packet, state_q.packet_left != 8'd0,
		state_q.phase == tga_rle_pkg::PH_REPEAT || state_q.phase == tga_rle_pkg::PH_RAW)
	`TGA_RLE_ASSERT_NXT(a_drain_holds,
		byte_xfer && state_q.phase == tga_rle_pkg::PH_DRAIN && !byte_item.end_of_data,
		state_q.phase == tga_rle_pkg::PH_DRAIN)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tga_rle_pkg::*;

	// Cycles with no transfer on either channel before the run is called hung.
	localparam int WATCHDOG_LIMIT = 1000;
	// Bytes of stimulus in all, directed part included; ignored bytes count as well.
	localparam int BYTE_BUDGET = 1650;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic        byte_valid;
	logic        byte_ready;
	in_item_t    byte_item;
	logic        pix_valid;
	logic        pix_ready;
	out_item_t   pix_item;

	tga_truecolor_rle_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_item   (pix_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be driven, and pixels the decoder still owes us.
	in_item_t    byte_q[$];
	out_item_t   pix_due[$];
	int unsigned bytes_queued;
	int unsigned bytes_taken;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned stuck_cycles;
	bit          byte_took;

	// Shadow of the configuration registers and of the decoder state.
	cfg_t        model_cfg;
	logic [2:0]  dec_phase;
	logic [31:0] px_left;
	logic [7:0]  pkt_left;
	logic        pkt_repeat;
	logic        pkt_over;
	logic [1:0]  byte_idx;
	logic [23:0] bgr_acc;

	function automatic out_item_t make_px(logic [31:0] rgba, logic [7:0] n, logic [2:0] st,
			logic done);
		out_item_t px;
		px.pixel_rgba = rgba;
		px.copies = n;
		px.status = st;
		px.image_done = done;
		return px;
	endfunction

	// Finish the current image; without end_of_data the rest of the file is skipped.
	function automatic void close_image(bit last);
		px_left = '0;
		pkt_left = '0;
		pkt_over = 1'b0;
		byte_idx = '0;
		dec_phase = last ? PH_HEAD : PH_DRAIN;
	endfunction

	function automatic out_item_t fail_px(logic [2:0] st, bit last);
		close_image(last);
		return make_px('0, '0, st, 1'b1);
	endfunction

	// Close a packet: last pixel of the image, missing next header, or on to the next header.
	function automatic out_item_t packet_end(logic [31:0] rgba, logic [7:0] n, bit last);
		pkt_left = '0;
		if (px_left == 0) begin
			close_image(last);
			return make_px(rgba, n, ST_PIXEL, 1'b1);
		end
		if (last)
			return fail_px(ST_NO_HEADER, last);
		dec_phase = PH_HEAD;
		return make_px(rgba, n, ST_PIXEL, 1'b0);
	endfunction

	// Advance the shadow decoder by one byte; return 1 when it yields a result.
	function automatic bit decode_byte(input in_item_t it, output out_item_t px);
		logic [7:0]  b;
		bit          last;
		bit          full;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [31:0] rgba;
		logic [7:0]  n;
		b = it.data_byte;
		last = it.end_of_data;
		px = '0;
		if (dec_phase == PH_DRAIN) begin
			if (last)
				close_image(1'b1);
			return 1'b0;
		end
		if (dec_phase > PH_DRAIN)
			dec_phase = PH_HEAD;
		// first byte of an image: latch the pixel count and the mode
		if (px_left == 0) begin
			px_left = (model_cfg.pixel_total != 0) ? model_cfg.pixel_total : 32'd1;
			dec_phase = model_cfg.run_length_mode ? PH_HEAD : PH_PLAIN;
			pkt_left = '0;
			pkt_over = 1'b0;
			byte_idx = '0;
		end
		if (dec_phase == PH_HEAD) begin
			pkt_repeat = b[7];
			pkt_left = {1'b0, b[6:0]} + 8'd1;
			pkt_over = ({24'd0, pkt_left} > px_left);
			byte_idx = '0;
			dec_phase = pkt_repeat ? PH_REPEAT : PH_RAW;
			if (last) begin
				px = fail_px(pkt_repeat ? ST_SHORT_REP : ST_SHORT_RAW, last);
				return 1'b1;
			end
			return 1'b0;
		end
		// the alpha setting is looked at on every byte, so the pixel width can shift mid-pixel
		full = (byte_idx == 2'd3) || (byte_idx == 2'd2 && !model_cfg.pixel_has_alpha);
		if (!full) begin
			if (byte_idx == 2'd0)
				bgr_acc = {16'd0, b};
			else
				bgr_acc[8 * byte_idx +: 8] = b;
			byte_idx = byte_idx + 2'd1;
			if (last) begin
				px = fail_px(dec_phase == PH_REPEAT ? ST_SHORT_REP :
					(dec_phase == PH_RAW ? ST_SHORT_RAW : ST_SHORT_PLAIN), last);
				return 1'b1;
			end
			return 1'b0;
		end
		if (byte_idx == 2'd3) begin
			red = bgr_acc[23:16];
			alpha = model_cfg.pixel_has_alpha ? b : 8'hFF;
		end else begin
			red = b;
			alpha = 8'hFF;
		end
		rgba = {alpha, bgr_acc[7:0], bgr_acc[15:8], red};
		byte_idx = '0;
		if (dec_phase == PH_REPEAT) begin
			n = pkt_left;
			if (pkt_over) begin
				px = fail_px(ST_OVERFLOW, last);
				return 1'b1;
			end
			px_left = px_left - {24'd0, n};
			px = packet_end(rgba, n, last);
			return 1'b1;
		end
		if (dec_phase == PH_RAW) begin
			pkt_left = pkt_left - 8'd1;
			if (pkt_left != 0) begin
				if (last) begin
					px = fail_px(ST_SHORT_RAW, last);
					return 1'b1;
				end
				// an oversized raw packet is swallowed silently until its end
				if (pkt_over)
					return 1'b0;
				px_left = px_left - 32'd1;
				px = make_px(rgba, 8'd1, ST_PIXEL, 1'b0);
				return 1'b1;
			end
			if (pkt_over) begin
				px = fail_px(ST_OVERFLOW, last);
				return 1'b1;
			end
			px_left = px_left - 32'd1;
			px = packet_end(rgba, 8'd1, last);
			return 1'b1;
		end
		// uncompressed stream
		px_left = px_left - 32'd1;
		if (px_left == 0) begin
			close_image(last);
			px = make_px(rgba, 8'd1, ST_PIXEL, 1'b1);
			return 1'b1;
		end
		if (last) begin
			px = fail_px(ST_SHORT_PLAIN, last);
			return 1'b1;
		end
		px = make_px(rgba, 8'd1, ST_PIXEL, 1'b0);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h (result %0d, t=%0t)", what, got, want,
			results_seen, $time);
		mismatches++;
	endtask

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Monitor: check results first, then predict from the byte taken at this edge.
	// A result never leaves on the edge of its own byte, so the order is safe.
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t px;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				if (pix_due.size() == 0) begin
					report_mismatch("result with nothing expected", pix_item.pixel_rgba, '0);
				end else begin
					want = pix_due.pop_front();
					if (pix_item.pixel_rgba !== want.pixel_rgba)
						report_mismatch("pixel_rgba", pix_item.pixel_rgba, want.pixel_rgba);
					if (pix_item.copies !== want.copies)
						report_mismatch("copies", pix_item.copies, want.copies);
					if (pix_item.status !== want.status)
						report_mismatch("status", pix_item.status, want.status);
					if (pix_item.image_done !== want.image_done)
						report_mismatch("image_done", pix_item.image_done, want.image_done);
				end
				results_seen++;
			end
			if (byte_valid && byte_ready) begin
				if (decode_byte(byte_item, px))
					pix_due = {pix_due, px};
				bytes_taken++;
				byte_took = 1'b1;
			end
			// watchdog: any transfer on either side resets the count
			if ((byte_valid && byte_ready) || (pix_valid && pix_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Driver: drop valid after a transfer, hold off for the chosen gap, then present the next byte.
	always @(negedge clk) begin : byte_driver
		bit          nv;
		in_item_t    ni;
		int unsigned gap_left;
		bit          calm;
		nv = byte_valid;
		ni = byte_item;
		if (byte_took)
			nv = 1'b0;
		byte_took = 1'b0;
		if ($urandom_range(0, 149) == 0)
			calm = !calm;
		if (arst_n && !nv) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (byte_q.size() > 0) begin
				ni = byte_q.pop_front();
				nv = 1'b1;
				gap_left = calm ? 0 : idle_len();
			end
		end
		byte_valid <= nv;
		byte_item <= ni;
	end

	// Receiver: stall pix_ready in random stretches, with calm stretches of none.
	always @(negedge clk) begin : pix_sink
		int unsigned stall_left;
		bit          calm;
		if ($urandom_range(0, 149) == 0)
			calm = !calm;
		if (stall_left == 0 && !calm)
			stall_left = idle_len();
		if (stall_left > 0) begin
			stall_left--;
			pix_ready <= 1'b0;
		end else begin
			pix_ready <= 1'b1;
		end
	end

	task automatic push_byte(logic [7:0] b, logic eod);
		in_item_t it;
		it.data_byte = b;
		it.end_of_data = eod;
		byte_q = {byte_q, it};
		bytes_queued++;
	endtask

	// Wait until every byte is taken and every result is in, then let the pipe empty.
	task automatic settle();
		while (bytes_taken != bytes_queued || pix_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers while the decoder is idle.
	task automatic set_config(bit rle, bit alpha, logic [31:0] total);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_RUN_LENGTH_MODE;
		cfg_wdata <= {31'd0, rle};
		@(negedge clk);
		cfg_index <= REG_PIXEL_HAS_ALPHA;
		cfg_wdata <= {31'd0, alpha};
		@(negedge clk);
		cfg_index <= REG_PIXEL_TOTAL;
		cfg_wdata <= total;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_cfg.run_length_mode = rle;
		model_cfg.pixel_has_alpha = alpha;
		model_cfg.pixel_total = total;
	endtask

	// Build one image's bytes: mostly well formed, sometimes cut short,
	// sometimes followed by junk up to end_of_data.
	task automatic gen_image(bit rle, bit alpha, logic [31:0] total);
		logic [7:0]  img[$];
		longint      left;
		int unsigned bpp;
		int unsigned cnt;
		int unsigned npix;
		int unsigned kind;
		bit          rep;
		bit          overflowed;
		bpp = alpha ? 4 : 3;
		left = (total == 0) ? 1 : total;
		overflowed = 1'b0;
		if (!rle) begin
			npix = (left < 20) ? 32'(left) : 20;
			repeat (npix * bpp) img = {img, 8'($urandom)};
		end else begin
			while (left > 0 && !overflowed && img.size() < 90) begin
				if ($urandom_range(0, 11) == 0 && left < 128)
					cnt = $urandom_range(32'(left) + 1, 128);
				else if ($urandom_range(0, 3) == 0)
					cnt = $urandom_range(1, (left < 128) ? 32'(left) : 128);
				else
					cnt = $urandom_range(1, (left < 6) ? 32'(left) : 6);
				rep = $urandom_range(0, 1);
				img = {img, {rep, 7'(cnt - 1)}};
				repeat ((rep ? 1 : cnt) * bpp) img = {img, 8'($urandom)};
				if (cnt > left)
					overflowed = 1'b1;
				else
					left -= cnt;
			end
		end
		kind = $urandom_range(0, 9);
		if (kind == 7 && img.size() > 1)
			repeat ($urandom_range(1, img.size() - 1)) void'(img.pop_back());
		else if (kind >= 8)
			repeat ($urandom_range(1, 4)) img = {img, 8'($urandom)};
		foreach (img[i])
			push_byte(img[i], i == img.size() - 1);
	endtask

	function automatic logic [31:0] pick_total();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd4294836225;
			3: return $urandom_range(100, 400);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		byte_valid = 1'b0;
		byte_item = '0;
		pix_ready = 1'b0;
		bytes_queued = 0;
		bytes_taken = 0;
		results_seen = 0;
		mismatches = 0;
		stuck_cycles = 0;
		byte_took = 1'b0;
		// shadow state after reset
		model_cfg.run_length_mode = 1'b1;
		model_cfg.pixel_has_alpha = 1'b1;
		model_cfg.pixel_total = 32'd1;
		dec_phase = PH_HEAD;
		px_left = '0;
		pkt_left = '0;
		pkt_repeat = 1'b0;
		pkt_over = 1'b0;
		byte_idx = '0;
		bgr_acc = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-pixel repeat packet that ends the file.
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);

		// Largest total, BGR: a 128-copy repeat, then a header carrying end_of_data,
		// then a raw packet ending the file with pixels still owed.
		set_config(1'b1, 1'b0, 32'hFFFF_FFFF);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'h0F, 1'b1);

		// Packet larger than the image, drained to end_of_data; then a cut repeat pixel.
		set_config(1'b1, 1'b0, 32'd2);
		push_byte(8'h82, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'hC3, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7E, 1'b1);

		// Plain stream with a zero total: one pixel, a skipped byte, then a cut pixel.
		set_config(1'b0, 1'b1, 32'd0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h11, 1'b1);
		push_byte(8'h22, 1'b1);

		// Drop alpha after three bytes: the fourth byte still closes the pixel, opaque.
		set_config(1'b0, 1'b1, 32'd1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		set_config(1'b0, 1'b0, 32'd1);
		push_byte(8'hFE, 1'b1);

		// Random settings, a few images each.
		while (bytes_queued < BYTE_BUDGET) begin : random_phase
			bit          rle;
			bit          alpha;
			logic [31:0] total;
			rle = ($urandom_range(0, 3) != 0);
			alpha = $urandom_range(0, 1);
			total = pick_total();
			set_config(rle, alpha, total);
			repeat ($urandom_range(1, 3)) gen_image(rle, alpha, total);
		end

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tga_rle_pkg.sv
rtl/tga_rle_step.sv
rtl/tga_rle_outreg.sv
rtl/tga_truecolor_rle_decoder.sv
tb/testbench.sv
